/* rtl/core/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // Configuration port geometry.
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN_B = 1'b1;

    // Reset values of the history length registers.
    localparam logic [CFG_W-1:0] HIST_LEN_A_RST = 6'd25;
    localparam logic [CFG_W-1:0] HIST_LEN_B_RST = 6'd20;

    // Chooser: values 2 and 3 select component B.
    localparam logic [1:0] SEL_MAX  = 2'd3;
    localparam logic [1:0] SEL_MIN  = 2'd0;
    localparam logic [1:0] SEL_INIT = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    // Commands from the controller to each gshare component.
    typedef struct packed {
        logic lookup;   // latch index and read the table
        logic update;   // train the counter and shift the history
        logic clear;    // write the reset value at the clear address
    } comp_ctrl_t;

endpackage

/* rtl/core/tbp_branch_if.sv */
// ----------------------------------------------------------------------------
// tbp_branch_if
// Channel that carries one resolved branch per item.
// ----------------------------------------------------------------------------
interface tbp_branch_if;
    logic        valid;
    logic        ready;
    logic [63:0] branch_pc;
    logic        taken;

    modport source (output valid, output branch_pc, output taken, input ready);
    modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

/* rtl/core/tbp_result_if.sv */
// ----------------------------------------------------------------------------
// tbp_result_if
// Channel that carries one prediction result per item.
// ----------------------------------------------------------------------------
interface tbp_result_if;
    logic valid;
    logic ready;
    logic predict_taken;
    logic used_b;
    logic mispredict;

    modport source (output valid, output predict_taken, output used_b,
                    output mispredict, input ready);
    modport sink   (input valid, input predict_taken, input used_b,
                    input mispredict, output ready);
endinterface

/* rtl/core/tbp_gshare.sv */
// ----------------------------------------------------------------------------
// tbp_gshare
// One gshare component: history register, counter table in a synchronous
// memory, index hashing and counter training.
// ----------------------------------------------------------------------------
module tbp_gshare #(
    parameter int INDEX_BITS   = 15,
    parameter int COUNTER_BITS = 2,
    parameter int HISTORY_MAX  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbp_pkg::comp_ctrl_t      ctrl,
    input  logic [INDEX_BITS-1:0]    clr_addr,
    input  logic [INDEX_BITS-1:0]    pc_low,
    input  logic                     taken,
    input  logic [tbp_pkg::CFG_W-1:0] hist_len,
    output logic                     pred
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int HW    = (INDEX_BITS > HISTORY_MAX) ? INDEX_BITS : HISTORY_MAX;
    localparam logic [COUNTER_BITS-1:0] CNT_INIT = COUNTER_BITS'(1 << (COUNTER_BITS - 1));
    localparam logic [6:0] HMAX = 7'(HISTORY_MAX);

    logic [COUNTER_BITS-1:0] table_mem [DEPTH];
    logic [COUNTER_BITS-1:0] rd_reg;
    logic [INDEX_BITS-1:0]   idx_reg;
    logic [HISTORY_MAX-1:0]  hist_reg;
    logic [HISTORY_MAX-1:0]  hist_next;
    logic [HISTORY_MAX-1:0]  mask;
    logic [6:0]              eff_len;
    logic [HW-1:0]           hist_wide;
    logic [INDEX_BITS-1:0]   idx;
    logic [COUNTER_BITS-1:0] trained;

    // Clamp the configured length into 1..HISTORY_MAX.
    always_comb
    begin
        if (hist_len == '0)
        begin
            eff_len = 7'd1;
        end
        else if ({1'b0, hist_len} > HMAX)
        begin
            eff_len = HMAX;
        end
        else
        begin
            eff_len = {1'b0, hist_len};
        end
    end

    // History mask: one bit per position below the effective length.
    always_comb
    begin
        for (int i = 0; i < HISTORY_MAX; i++)
        begin
            mask[i] = (7'(i) < eff_len);
        end
    end

    // Table index from the branch address and the masked history.
    assign hist_wide = HW'(hist_reg & mask);
    assign idx       = pc_low ^ hist_wide[INDEX_BITS-1:0];

    // Saturating counter training.
    always_comb
    begin
        if (taken)
        begin
            trained = (rd_reg != '1) ? rd_reg + COUNTER_BITS'(1) : rd_reg;
        end
        else
        begin
            trained = (rd_reg != '0) ? rd_reg - COUNTER_BITS'(1) : rd_reg;
        end
    end

    // The upper half of the counter range predicts taken.
    assign pred = rd_reg[COUNTER_BITS-1];

    assign hist_next = {hist_reg[HISTORY_MAX-2:0], taken} & mask;

    // Counter table: one read and one write port, registered read data.
    always_ff @(posedge clk)
    begin
        if (ctrl.lookup)
        begin
            rd_reg  <= table_mem[idx];
            idx_reg <= idx;
        end
        if (ctrl.clear)
        begin
            table_mem[clr_addr] <= CNT_INIT;
        end
        else if (ctrl.update)
        begin
            table_mem[idx_reg] <= trained;
        end
    end

    // Global history shift register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (ctrl.update)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

/* rtl/core/tournament_branch_predictor_unit.sv */
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit
// Tournament predictor over two gshare components with a global chooser.
// ----------------------------------------------------------------------------
// Each item is one resolved branch; the result is the prediction made before
// training, the component that supplied it and whether it missed. Both
// counter tables are read with the hashed index when an item is accepted;
// the lookup state then evaluates, writes the trained counters back and
// shifts the histories, and waits while the output still holds a result.
// A new item is accepted only once the previous one has written back, so
// that no read can meet a pending write to the same entry. After reset the
// block runs a clearing pass through every entry of both tables before it
// takes the first item; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit #(
    parameter int INDEX_BITS   = 15,
    parameter int COUNTER_BITS = 2,
    parameter int HISTORY_MAX  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbp_pkg::CFG_W-1:0]     cfg_wdata,
    tbp_branch_if.sink                    branch,
    tbp_result_if.source                  result
);

    tbp_pkg::state_t         state_reg, state_next;
    logic [INDEX_BITS-1:0]   clr_cnt_reg;
    logic [tbp_pkg::CFG_W-1:0] len_a_reg, len_b_reg;
    logic [1:0]              chooser_reg, chooser_next;
    logic                    taken_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_pred_reg, out_used_b_reg, out_miss_reg;
    tbp_pkg::comp_ctrl_t     ctrl;
    logic                    accept, fire;
    logic                    pred_a, pred_b, use_b, pred;

    assign branch.ready = (state_reg == tbp_pkg::ST_IDLE);
    assign accept       = branch.valid && branch.ready;
    assign fire         = (state_reg == tbp_pkg::ST_LOOKUP) && (!out_valid_reg || result.ready);

    assign ctrl.lookup = accept;
    assign ctrl.update = fire;
    assign ctrl.clear  = (state_reg == tbp_pkg::ST_CLEAR);

    // Two gshare components.
    tbp_gshare #(
        .INDEX_BITS  (INDEX_BITS),
        .COUNTER_BITS(COUNTER_BITS),
        .HISTORY_MAX (HISTORY_MAX)
    ) u_comp_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .clr_addr(clr_cnt_reg),
        .pc_low  (branch.branch_pc[INDEX_BITS-1:0]),
        .taken   (taken_reg),
        .hist_len(len_a_reg),
        .pred    (pred_a)
    );

    tbp_gshare #(
        .INDEX_BITS  (INDEX_BITS),
        .COUNTER_BITS(COUNTER_BITS),
        .HISTORY_MAX (HISTORY_MAX)
    ) u_comp_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .clr_addr(clr_cnt_reg),
        .pc_low  (branch.branch_pc[INDEX_BITS-1:0]),
        .taken   (taken_reg),
        .hist_len(len_b_reg),
        .pred    (pred_b)
    );

    // Final prediction from the chooser.
    assign use_b = chooser_reg[1];
    assign pred  = use_b ? pred_b : pred_a;

    // Controller state sequence.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbp_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            tbp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tbp_pkg::ST_LOOKUP;
                end
            end
            tbp_pkg::ST_LOOKUP:
            begin
                if (fire)
                begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbp_pkg::ST_CLEAR;
            end
        endcase
    end

    // Chooser moves toward the component that alone was right.
    always_comb
    begin
        chooser_next = chooser_reg;
        if (pred_a != pred_b)
        begin
            if (pred_a == taken_reg)
            begin
                if (chooser_reg != tbp_pkg::SEL_MIN)
                begin
                    chooser_next = chooser_reg - 2'd1;
                end
            end
            else if (chooser_reg != tbp_pkg::SEL_MAX)
            begin
                chooser_next = chooser_reg + 2'd1;
            end
        end
    end

    // Output register valid flag.
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbp_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            chooser_reg   <= tbp_pkg::SEL_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (ctrl.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + INDEX_BITS'(1);
            end
            if (fire)
            begin
                chooser_reg <= chooser_next;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= tbp_pkg::HIST_LEN_A_RST;
            len_b_reg <= tbp_pkg::HIST_LEN_B_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbp_pkg::REG_HIST_LEN_A: len_a_reg <= cfg_wdata;
                tbp_pkg::REG_HIST_LEN_B: len_b_reg <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // Item payload and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            taken_reg <= branch.taken;
        end
        if (fire)
        begin
            out_pred_reg   <= pred;
            out_used_b_reg <= use_b;
            out_miss_reg   <= pred ^ taken_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.predict_taken = out_pred_reg;
    assign result.used_b        = out_used_b_reg;
    assign result.mispredict    = out_miss_reg;

endmodule

/* rtl/core/tbp_checker.sv */
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the tournament predictor, bound to the top level.
// ----------------------------------------------------------------------------
module tbp_checker (
    input logic clk,
    input logic rst_n,
    input logic branch_valid,
    input logic branch_ready,
    input logic result_valid,
    input logic result_ready,
    input logic predict_taken,
    input logic used_b,
    input logic mispredict
);

    // Only one item is in flight: an accepted item closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (branch_valid && branch_ready) |=> !branch_ready)
        else $error("input taken again while an item is in flight");

    // A new result appears only after the input was closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(branch_ready))
        else $error("result appeared without an item in flight");

    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result dropped while stalled");

    // A waiting result keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            ($stable(predict_taken) && $stable(used_b) && $stable(mispredict)))
        else $error("result changed while stalled");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .branch_valid (branch.valid),
    .branch_ready (branch.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .predict_taken(result.predict_taken),
    .used_b       (result.used_b),
    .mispredict   (result.mispredict)
);

/* tb/sv/tournament_branch_predictor_unit_test.sv */
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit_test
// Self-checking bench for the two-component gshare tournament predictor.
// Resolved branches go in on the branch channel, and every prediction that
// comes back is compared with a cycle-free software copy of both counter
// tables, both history registers and the chooser. Directed items cover the
// reset state, out-of-range history lengths and a history shortened in the
// middle of a run. Random phases then replay looping branch patterns mixed
// with noise under changing history lengths. Both channel ends stall at
// random.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INDEX_BITS   = 15;
    localparam int COUNTER_BITS = 2;
    localparam int HISTORY_MAX  = 32;
    localparam int TABLE_DEPTH  = 1 << INDEX_BITS;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 85;
    localparam int POOL_SIZE    = 8;
    localparam int LEN_W        = tbp_pkg::CFG_W;
    localparam int IDX_W        = tbp_pkg::CFG_IDX_W;

    localparam logic [COUNTER_BITS-1:0] CTR_WEAK_TAKEN =
        COUNTER_BITS'(1 << (COUNTER_BITS - 1));
    localparam logic [COUNTER_BITS-1:0] CTR_MAX        = '1;

    // One prediction as the block reports it.
    typedef struct packed {
        logic predict_taken;
        logic used_b;
        logic mispredict;
    } branch_outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0] cfg_wdata;

    tbp_branch_if branch_ch();
    tbp_result_if result_ch();

    // Software copy of the predictor state.
    logic [COUNTER_BITS-1:0] pht_a [0:TABLE_DEPTH-1];
    logic [COUNTER_BITS-1:0] pht_b [0:TABLE_DEPTH-1];
    logic [HISTORY_MAX-1:0] ghist_a;
    logic [HISTORY_MAX-1:0] ghist_b;
    logic [1:0] sel_ctr;
    logic [LEN_W-1:0] hist_len_a;
    logic [LEN_W-1:0] hist_len_b;

    branch_outcome_t pending_predictions [$];
    int error_count;
    int result_count;
    bit stall_enable;

    tournament_branch_predictor_unit #(
        .INDEX_BITS  (INDEX_BITS),
        .COUNTER_BITS(COUNTER_BITS),
        .HISTORY_MAX (HISTORY_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .branch   (branch_ch),
        .result   (result_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("tournament_branch_predictor_unit_test: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    // A length of zero keeps one bit; anything past the maximum keeps all.
    function automatic logic [HISTORY_MAX-1:0] length_mask(input logic [LEN_W-1:0] len);
        int n;
        logic [HISTORY_MAX-1:0] one;
        n = int'(len);
        one = HISTORY_MAX'(1);
        if (n < 1)
            n = 1;
        if (n >= HISTORY_MAX)
            return '1;
        return (one << n) - one;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] saturate_train(
        input logic [COUNTER_BITS-1:0] cnt,
        input logic up
    );
        if (up)
            return (cnt != CTR_MAX) ? cnt + 1'b1 : cnt;
        return (cnt != '0) ? cnt - 1'b1 : cnt;
    endfunction

    // Predict one branch from the current state, then train on its outcome.
    function automatic branch_outcome_t predict_and_train(
        input logic [63:0] pc,
        input logic tk
    );
        logic [HISTORY_MAX-1:0] mask_a;
        logic [HISTORY_MAX-1:0] mask_b;
        logic [INDEX_BITS-1:0] idx_a;
        logic [INDEX_BITS-1:0] idx_b;
        logic pred_a;
        logic pred_b;
        branch_outcome_t outcome;
        mask_a = length_mask(hist_len_a);
        mask_b = length_mask(hist_len_b);
        idx_a = INDEX_BITS'(pc ^ 64'(ghist_a & mask_a));
        idx_b = INDEX_BITS'(pc ^ 64'(ghist_b & mask_b));
        pred_a = pht_a[idx_a] >= CTR_WEAK_TAKEN;
        pred_b = pht_b[idx_b] >= CTR_WEAK_TAKEN;
        outcome.used_b = sel_ctr >= tbp_pkg::SEL_INIT;
        outcome.predict_taken = outcome.used_b ? pred_b : pred_a;
        outcome.mispredict = outcome.predict_taken != tk;

        pht_a[idx_a] = saturate_train(pht_a[idx_a], tk);
        pht_b[idx_b] = saturate_train(pht_b[idx_b], tk);
        ghist_a = {ghist_a[HISTORY_MAX-2:0], tk} & mask_a;
        ghist_b = {ghist_b[HISTORY_MAX-2:0], tk} & mask_b;

        // The chooser only moves when exactly one component was right.
        if (pred_a != pred_b)
        begin
            if (pred_a == tk)
            begin
                if (sel_ctr != tbp_pkg::SEL_MIN)
                    sel_ctr = sel_ctr - 1'b1;
            end
            else if (sel_ctr != tbp_pkg::SEL_MAX)
                sel_ctr = sel_ctr + 1'b1;
        end
        return outcome;
    endfunction

    // Offer one branch after a random gap and record its prediction on accept.
    task automatic send_branch(input logic [63:0] pc, input logic tk);
        int gap;
        gap = stall_enable ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            branch_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        branch_ch.valid     <= 1'b1;
        branch_ch.branch_pc <= pc;
        branch_ch.taken     <= tk;
        do @(posedge clk); while (branch_ch.ready !== 1'b1);
        pending_predictions.push_back(predict_and_train(pc, tk));
    endtask

    // Stop offering branches and wait until every prediction has come back.
    task automatic wait_for_results();
        branch_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_predictions.size() != 0);
    endtask

    // Both length registers are written back to back while the block is idle.
    task automatic set_history_lengths(input logic [LEN_W-1:0] len_a,
                                       input logic [LEN_W-1:0] len_b);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= tbp_pkg::REG_HIST_LEN_A;
        cfg_wdata <= len_a;
        @(posedge clk);
        cfg_index <= tbp_pkg::REG_HIST_LEN_B;
        cfg_wdata <= len_b;
        @(posedge clk);
        cfg_we <= 1'b0;
        hist_len_a = len_a;
        hist_len_b = len_b;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LEN_W'(1);
            2: return LEN_W'(HISTORY_MAX);
            3: return '1;
            default: return LEN_W'($urandom_range(1, HISTORY_MAX));
        endcase
    endfunction

    // Reset lengths, with the address extremes and both outcomes.
    task automatic test_default_lengths();
        send_branch(64'h0, 1'b1);
        send_branch('1, 1'b0);
        send_branch(64'h0, 1'b1);
        send_branch(64'h0, 1'b1);
        send_branch(64'h8000_0000_0000_0000, 1'b0);
        send_branch(64'h5555_5555_aaaa_aaaa, 1'b1);
    endtask

    // Zero is taken as one bit, and lengths past the maximum as the maximum.
    task automatic test_length_extremes();
        set_history_lengths('0, '1);
        send_branch(64'h0000_0000_0000_7fff, 1'b1);
        send_branch(64'h0000_0000_0000_7fff, 1'b0);
        send_branch(64'h0000_0000_0000_7ffe, 1'b0);
        send_branch(64'hffff_ffff_ffff_0000, 1'b1);
        send_branch(64'h0000_0000_0000_7fff, 1'b1);
        set_history_lengths(LEN_W'(HISTORY_MAX), LEN_W'(1));
        send_branch(64'h1234_5678_9abc_def0, 1'b0);
        send_branch(64'h1234_5678_9abc_def0, 1'b0);
        send_branch(64'h1234_5678_9abc_def1, 1'b1);
        send_branch(64'hfedc_ba98_7654_3210, 1'b0);
        send_branch(64'h1234_5678_9abc_def0, 1'b1);
    endtask

    // Build a long history, then cut it short; the dropped bits stay gone.
    task automatic test_history_shortening();
        set_history_lengths(LEN_W'(HISTORY_MAX), LEN_W'(HISTORY_MAX));
        send_branch(64'h0000_0000_0000_0100, 1'b1);
        send_branch(64'h0000_0000_0000_0200, 1'b1);
        send_branch(64'h0000_0000_0000_0300, 1'b1);
        send_branch(64'h0000_0000_0000_0400, 1'b1);
        set_history_lengths(LEN_W'(3), LEN_W'(2));
        send_branch(64'h0000_0000_0000_0100, 1'b0);
        send_branch(64'h0000_0000_0000_0100, 1'b1);
        send_branch(64'h0000_0000_0000_0200, 1'b0);
        send_branch(64'h0000_0000_0000_0100, 1'b0);
    endtask

    // Phases of looping branches with periodic outcomes, plus random noise.
    task automatic test_random_traffic();
        logic [63:0] pool_pc [POOL_SIZE];
        logic [15:0] pattern [POOL_SIZE];
        int period [POOL_SIZE];
        int step [POOL_SIZE];
        int k;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_history_lengths(pick_length(), pick_length());
            stall_enable = (phase % 3) != 2;
            for (int j = 0; j < POOL_SIZE; j++)
            begin
                pool_pc[j] = {$urandom, $urandom};
                pattern[j] = 16'($urandom);
                period[j]  = $urandom_range(1, 16);
                step[j]    = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    send_branch(pool_pc[k], pattern[k][step[k]]);
                    step[k] = (step[k] + 1) % period[k];
                end
                else
                    send_branch({$urandom, $urandom}, 1'($urandom_range(0, 1)));
            end
        end
        stall_enable = 1'b1;
    endtask

    // Result side: random stalls, then compare each item with the oldest prediction.
    initial
    begin : result_checker
        int stall;
        branch_outcome_t want;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = stall_enable ? $urandom_range(0, 8) : 0;
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            result_count++;
            if (pending_predictions.size() == 0)
                report_mismatch($sformatf("result %0d arrived with no branch outstanding",
                                          result_count));
            else
            begin
                want = pending_predictions.pop_front();
                if (result_ch.predict_taken !== want.predict_taken)
                    report_mismatch($sformatf("result %0d predict_taken %b, expected %b",
                                              result_count, result_ch.predict_taken,
                                              want.predict_taken));
                if (result_ch.used_b !== want.used_b)
                    report_mismatch($sformatf("result %0d used_b %b, expected %b",
                                              result_count, result_ch.used_b, want.used_b));
                if (result_ch.mispredict !== want.mispredict)
                    report_mismatch($sformatf("result %0d mispredict %b, expected %b",
                                              result_count, result_ch.mispredict,
                                              want.mispredict));
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= tbp_pkg::REG_HIST_LEN_A;
        cfg_wdata           <= '0;
        branch_ch.valid     <= 1'b0;
        branch_ch.branch_pc <= '0;
        branch_ch.taken     <= 1'b0;
        error_count  = 0;
        result_count = 0;
        stall_enable = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pht_a[i] = CTR_WEAK_TAKEN;
            pht_b[i] = CTR_WEAK_TAKEN;
        end
        ghist_a    = '0;
        ghist_b    = '0;
        sel_ctr    = tbp_pkg::SEL_INIT;
        hist_len_a = tbp_pkg::HIST_LEN_A_RST;
        hist_len_b = tbp_pkg::HIST_LEN_B_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_default_lengths();
        test_length_extremes();
        test_history_shortening();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tournament_branch_predictor_unit_test: clean");
        else
            $display("tournament_branch_predictor_unit_test: errors");
        $finish;
    end

endmodule
